@@ rtl/core/gmps_pkg.sv @@
`default_nettype none
package gmps_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int CFG_W  = 11;
  localparam int CMP_W  = 13;
  localparam int VAL_W  = 16;
  localparam int SUM_W  = 33;
  localparam int OUT_W  = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int PSUM_W = SUM_W + 1;

  localparam logic [2:0] REG_GRID_ROWS      = 3'd0;
  localparam logic [2:0] REG_GRID_COLS      = 3'd1;
  localparam logic [2:0] REG_WALL_START_ROW = 3'd2;
  localparam logic [2:0] REG_WALL_START_COL = 3'd3;
  localparam logic [2:0] REG_WALL_END_ROW   = 3'd4;
  localparam logic [2:0] REG_WALL_END_COL   = 3'd5;

  typedef struct packed {
    logic                    ok;
    logic signed [SUM_W-1:0] sum;
  } psum_t;

endpackage
`default_nettype wire

@@ rtl/core/gmps_ram.sv @@
`default_nettype none
module gmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/grid_max_path_sum_with_wall.sv @@
`default_nettype none
// Best right/down path sum through a grid with one wall segment. Cells arrive in row-major
// order, one beat per cell, and the block takes a new cell on every clock. The input
// stalls only while the last cell of a grid waits behind an earlier result beat that has
// not been taken. Each cell does one read-modify-write of the column entry in a one-row
// buffer RAM: the entry is read when the beat is accepted and written back as it leaves
// stage 1, with the previous result forwarded when two beats in a row hit the same column.
// The result beat for a grid is registered as the last cell leaves stage 1 and holds the
// path sum in tdata and the reachable flag in tuser. The row buffer needs no clearing after
// reset, since the first row of every grid writes each column before it is read.
module grid_max_path_sum_with_wall (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [15:0] cell_value
  input  wire logic [gmps_pkg::VAL_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [31:0] path_sum
  output logic      [gmps_pkg::OUT_W-1:0]   out_tdata,
  // [0] reachable
  output logic      [0:0]                   out_tuser,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [gmps_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [gmps_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [gmps_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  import gmps_pkg::*;

  logic [CFG_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [CFG_W-1:0] wsr_r, wsr_nxt, wsc_r, wsc_nxt, wer_r, wer_nxt, wec_r, wec_nxt;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic                    s1_valid_r, s1_valid_nxt;
  logic signed [VAL_W-1:0] s1_val_r, s1_val_nxt;
  logic [COL_W-1:0]        s1_col_r, s1_col_nxt;
  logic                    s1_r0_r, s1_r0_nxt, s1_c0_r, s1_c0_nxt;
  logic                    s1_hw_r, s1_hw_nxt, s1_vw_r, s1_vw_nxt;
  logic                    s1_last_r, s1_last_nxt, s1_fwd_r, s1_fwd_nxt;

  psum_t left_r, left_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_sum_r, out_sum_nxt;
  logic             out_ok_r, out_ok_nxt;

  logic [CMP_W-1:0] rows_eff, cols_eff;
  logic [CMP_W-1:0] sr, sc, er, ec, r_ext, c_ext, row_inc, col_inc;
  logic             wrap_col, wrap_row, accept, cfg_wr, s1_fire, swap;
  logic [PSUM_W-1:0] ram_rdata, ram_wdata;
  psum_t up, left, res;
  logic signed [SUM_W-1:0] val_ext;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_GRID_ROWS:      cfg_prdata = DATA_W'(rows_r);
      REG_GRID_COLS:      cfg_prdata = DATA_W'(cols_r);
      REG_WALL_START_ROW: cfg_prdata = DATA_W'(wsr_r);
      REG_WALL_START_COL: cfg_prdata = DATA_W'(wsc_r);
      REG_WALL_END_ROW:   cfg_prdata = DATA_W'(wer_r);
      REG_WALL_END_COL:   cfg_prdata = DATA_W'(wec_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (rows_r == '0) begin
      rows_eff = CMP_W'(1);
    end else if (CMP_W'(rows_r) > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = CMP_W'(rows_r);
    end
    if (cols_r == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(cols_r) > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = CMP_W'(cols_r);
    end
  end

  always_comb begin
    swap = (wsr_r > wer_r) || (wsc_r > wec_r);
    sr = CMP_W'(swap ? wer_r : wsr_r);
    er = CMP_W'(swap ? wsr_r : wer_r);
    sc = CMP_W'(swap ? wec_r : wsc_r);
    ec = CMP_W'(swap ? wsc_r : wec_r);
    r_ext   = CMP_W'(row_r);
    c_ext   = CMP_W'(col_r);
    row_inc = r_ext + CMP_W'(1);
    col_inc = c_ext + CMP_W'(1);
    wrap_col = col_inc >= cols_eff;
    wrap_row = row_inc >= rows_eff;
  end

  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign accept    = in_tvalid && in_tready;

  assign val_ext = {{(SUM_W-VAL_W){s1_val_r[VAL_W-1]}}, s1_val_r};

  always_comb begin
    if (s1_r0_r) begin
      up.sum = '0;
      up.ok  = s1_c0_r;
    end else if (s1_fwd_r) begin
      up = left_r;
    end else begin
      up = psum_t'(ram_rdata);
    end
    if (s1_c0_r) begin
      left.sum = '0;
      left.ok  = s1_r0_r;
    end else begin
      left = left_r;
    end
    up.sum   = up.sum + val_ext;
    left.sum = left.sum + val_ext;
    if (s1_hw_r) begin
      res = left;
    end else if (s1_vw_r) begin
      res = up;
    end else if (up.ok && left.ok) begin
      res = (up.sum > left.sum) ? up : left;
    end else begin
      res = up.ok ? up : left;
    end
    if (!res.ok) begin
      res.sum = '0;
    end
  end

  assign ram_wdata = PSUM_W'(res);

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    wsr_nxt  = wsr_r;
    wsc_nxt  = wsc_r;
    wer_nxt  = wer_r;
    wec_nxt  = wec_r;
    if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_GRID_ROWS:      rows_nxt = cfg_pwdata[CFG_W-1:0];
        REG_GRID_COLS:      cols_nxt = cfg_pwdata[CFG_W-1:0];
        REG_WALL_START_ROW: wsr_nxt  = cfg_pwdata[CFG_W-1:0];
        REG_WALL_START_COL: wsc_nxt  = cfg_pwdata[CFG_W-1:0];
        REG_WALL_END_ROW:   wer_nxt  = cfg_pwdata[CFG_W-1:0];
        REG_WALL_END_COL:   wec_nxt  = cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end

    row_nxt      = row_r;
    col_nxt      = col_r;
    s1_val_nxt   = s1_val_r;
    s1_col_nxt   = s1_col_r;
    s1_r0_nxt    = s1_r0_r;
    s1_c0_nxt    = s1_c0_r;
    s1_hw_nxt    = s1_hw_r;
    s1_vw_nxt    = s1_vw_r;
    s1_last_nxt  = s1_last_r;
    s1_fwd_nxt   = s1_fwd_r;
    s1_valid_nxt = s1_fire ? 1'b0 : s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      s1_val_nxt   = in_tdata;
      s1_col_nxt   = col_r;
      s1_r0_nxt    = (r_ext == '0);
      s1_c0_nxt    = (c_ext == '0);
      s1_hw_nxt    = (sr == er) && (r_ext == sr) && (sc <= c_ext) && (c_ext < ec);
      s1_vw_nxt    = (sc == ec) && (c_ext == sc) && (sr <= r_ext) && (r_ext < er);
      s1_last_nxt  = wrap_col && wrap_row;
      s1_fwd_nxt   = s1_valid_r && (s1_col_r == col_r);
      if (wrap_col) begin
        col_nxt = '0;
        row_nxt = wrap_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end

    left_nxt      = s1_fire ? res : left_r;
    out_sum_nxt   = out_sum_r;
    out_ok_nxt    = out_ok_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = res.sum[OUT_W-1:0];
      out_ok_nxt    = res.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= CFG_W'(1);
      cols_r      <= CFG_W'(1);
      wsr_r       <= '0;
      wsc_r       <= '0;
      wer_r       <= '0;
      wec_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      wsr_r       <= wsr_nxt;
      wsc_r       <= wsc_nxt;
      wer_r       <= wer_nxt;
      wec_r       <= wec_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_val_r  <= s1_val_nxt;
    s1_col_r  <= s1_col_nxt;
    s1_r0_r   <= s1_r0_nxt;
    s1_c0_r   <= s1_c0_nxt;
    s1_hw_r   <= s1_hw_nxt;
    s1_vw_r   <= s1_vw_nxt;
    s1_last_r <= s1_last_nxt;
    s1_fwd_r  <= s1_fwd_nxt;
    out_sum_r <= out_sum_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  gmps_ram #(
    .WIDTH (PSUM_W),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_sum_r;
  assign out_tuser[0] = out_ok_r;

endmodule
`default_nettype wire

@@ rtl/core/gmps_checker.sv @@
`default_nettype none
module gmps_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [gmps_pkg::OUT_W-1:0] out_tdata,
  input wire logic [0:0]                 out_tuser
);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped or changed while stalled");

  // An unreachable end cell reports a zero sum.
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("unreachable result with nonzero sum");

  // With no result pending, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Reset leaves no result beat behind.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

endmodule

bind grid_max_path_sum_with_wall gmps_checker u_gmps_checker (.*);
`default_nettype wire
